// ===== hdl/pdh_pkg.sv =====
// Shared types, sizes and arithmetic helpers for the dwell-time heatmap unit.
// No dependencies.
package pdh_pkg;

    localparam int IMAGE_WIDTH  = 640;
    localparam int IMAGE_HEIGHT = 480;
    localparam int COUNT_BITS   = 16;

    localparam int PIXELS  = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int ADDR_W  = $clog2(PIXELS);
    localparam int CNT_W   = COUNT_BITS;
    localparam int OUT_W   = 16;

    localparam logic [7:0]  THRESH_RST   = 8'd75;
    localparam logic [15:0] MIN_STAY_RST = 16'd5;

    localparam logic CFG_THRESH   = 1'b0;
    localparam logic CFG_MIN_STAY = 1'b1;

    localparam logic OP_PROCESS = 1'b0;
    localparam logic OP_DRAIN   = 1'b1;

    typedef logic [CNT_W-1:0] t_cnt;

    localparam t_cnt CNT_MAX = '1;

    typedef struct packed {
        logic [7:0] bg;
        logic       bg_valid;
        logic       prev_fg;
        t_cnt       run;
        t_cnt       visits;
        t_cnt       avg;
    } t_entry;

    typedef struct packed {
        logic              valid;
        logic              oor;
        logic              drain;
        logic [ADDR_W-1:0] addr;
        logic              fg;
        t_entry            ent;
        logic              upd;
        t_cnt              n;
        t_cnt              vis_out;
    } t_ctx;

    typedef struct packed {
        t_cnt rem;
        t_cnt lq;
    } t_div;

    // One restoring division step: shift in the next dividend bit, subtract if it fits.
    function automatic t_div div_step(input t_cnt rem, input t_cnt lq, input t_cnt n);
        logic [CNT_W:0] t;
        t_div           r;
        t = {rem, lq[CNT_W-1]};
        if (t >= {1'b0, n}) begin
            t     = t - {1'b0, n};
            r.rem = t[CNT_W-1:0];
            r.lq  = {lq[CNT_W-2:0], 1'b1};
        end else begin
            r.rem = t[CNT_W-1:0];
            r.lq  = {lq[CNT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [OUT_W-1:0] sat_out(input t_cnt v);
        logic [CNT_W+OUT_W-1:0] ext;
        ext = {{OUT_W{1'b0}}, v};
        if (ext > (CNT_W+OUT_W)'({OUT_W{1'b1}})) begin
            return '1;
        end
        return ext[OUT_W-1:0];
    endfunction

    function automatic t_cnt sat_inc(input t_cnt v);
        return (v == CNT_MAX) ? v : v + t_cnt'(1);
    endfunction

endpackage

// ===== hdl/pixel_dwell_time_heatmap_unit.sv =====
// Per-pixel dwell-time heatmap: gray conversion, foreground test, run/visit statistics.
// Path: an accepted request passes through s1, ctx[0], the divider stages ctx[1..CNT_W] and the
// output register to o_out_valid. Throughput: one request per cycle while the output is not
// stalled; a request to a pixel still in flight waits until that pixel has been written back.
// Reset: synchronous, active low; a clearing pass then writes all 307200 entries with
// o_in_ready low, configuration writes taken throughout. Depends on pdh_pkg.
module pixel_dwell_time_heatmap_unit
    import pdh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_op,
    input  logic [8:0]  i_row,
    input  logic [9:0]  i_col,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic        i_in_area,
    input  logic        i_reload_background,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_foreground,
    output logic [15:0] o_dwell_average,
    output logic [15:0] o_visit_count,
    output logic        o_has_data
);

    typedef struct packed {
        logic              valid;
        logic              oor;
        logic              drain;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        gray;
        logic              area;
        logic              reload;
    } t_req;

    // Configuration registers
    logic [7:0]  r_thresh;
    logic [15:0] r_min_stay;

    // Per-pixel state memory, one read and one write port
    t_entry r_mem [PIXELS];
    t_entry r_rd;

    // Clearing pass after reset
    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;

    // Pipeline: s1 (memory data arrives), ctx[0] (product), ctx[1..CNT_W] (divider)
    t_req   r_s1;
    t_ctx   r_ctx  [CNT_W+1];
    t_cnt   r_prod_hi;
    t_cnt   r_prod_lo;
    t_cnt   r_run;
    t_cnt   r_rem  [1:CNT_W];
    t_cnt   r_lq   [1:CNT_W];

    // Output register
    logic        r_out_valid;
    logic        r_out_fg;
    logic [15:0] r_out_avg;
    logic [15:0] r_out_vis;
    logic        r_out_has;

    logic              w_adv;
    logic              w_hazard;
    logic              w_in_fire;
    logic              w_oor;
    logic [ADDR_W-1:0] w_addr;
    logic [21:0]       w_gray_sum;
    t_ctx              w_s1_ctx;
    logic [2*CNT_W-1:0] w_prod;
    logic [2*CNT_W-1:0] w_sum;
    t_div              w_step [CNT_W+1];
    t_ctx              w_last;
    t_cnt              w_avg_new;
    logic              w_we;
    logic [ADDR_W-1:0] w_wa;
    t_entry            w_wd;

    // Whole pipeline advances when the output register is free or being emptied.
    assign w_adv = !r_out_valid || i_out_ready;

    // Address and range check of the incoming request.
    assign w_oor  = (i_row >= 9'(IMAGE_HEIGHT)) || (i_col >= 10'(IMAGE_WIDTH));
    assign w_addr = ADDR_W'(i_row) * ADDR_W'(IMAGE_WIDTH) + ADDR_W'(i_col);

    // Interlock: hold a request whose pixel is anywhere between read and write-back.
    always_comb begin
        w_hazard = r_s1.valid && !r_s1.oor && (r_s1.addr == w_addr);
        for (int k = 0; k <= CNT_W; k++) begin
            if (r_ctx[k].valid && !r_ctx[k].oor && (r_ctx[k].addr == w_addr)) begin
                w_hazard = 1'b1;
            end
        end
    end

    assign o_in_ready = !r_clr_busy && w_adv && !(w_hazard && !w_oor);
    assign w_in_fire  = i_in_valid && o_in_ready;

    assign w_gray_sum = 22'(i_red) * 22'd4899 + 22'(i_green) * 22'd9617
                      + 22'(i_blue) * 22'd1868 + 22'd8192;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh   <= THRESH_RST;
            r_min_stay <= MIN_STAY_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_THRESH:   r_thresh   <= i_cfg_data[7:0];
                CFG_MIN_STAY: r_min_stay <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
            if (r_clr_addr == ADDR_W'(PIXELS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Stage s1: evaluate the pixel against the stored entry.
    always_comb begin
        t_entry e;
        logic [7:0] bg;
        logic [7:0] diff;
        logic       fg;
        e  = r_rd;
        bg = e.bg_valid ? e.bg : r_s1.gray;
        diff = (r_s1.gray >= bg) ? (r_s1.gray - bg) : (bg - r_s1.gray);
        fg = r_s1.area && (diff > r_thresh);

        w_s1_ctx         = '0;
        w_s1_ctx.valid   = r_s1.valid;
        w_s1_ctx.oor     = r_s1.oor;
        w_s1_ctx.drain   = r_s1.drain;
        w_s1_ctx.addr    = r_s1.addr;
        w_s1_ctx.ent     = e;
        w_s1_ctx.n       = e.visits;
        w_s1_ctx.vis_out = e.visits;
        if (r_s1.drain) begin
            // Report old statistics, then clear counters; keep background and prev bit.
            w_s1_ctx.ent.run    = '0;
            w_s1_ctx.ent.visits = '0;
        end else begin
            w_s1_ctx.fg = fg;
            if (fg && e.prev_fg) begin
                w_s1_ctx.ent.run = sat_inc(e.run);
            end else if ({{(32-CNT_W){1'b0}}, e.run} > {16'b0, r_min_stay}) begin
                w_s1_ctx.upd        = 1'b1;
                w_s1_ctx.ent.visits = sat_inc(e.visits);
                w_s1_ctx.n          = sat_inc(e.visits);
                w_s1_ctx.ent.run    = '0;
            end
            w_s1_ctx.vis_out     = w_s1_ctx.ent.visits;
            w_s1_ctx.ent.prev_fg = fg;
            w_s1_ctx.ent.bg      = r_s1.reload ? r_s1.gray : bg;
            w_s1_ctx.ent.bg_valid = 1'b1;
        end
    end

    assign w_prod = (2*CNT_W)'(r_rd.avg) * (2*CNT_W)'(w_s1_ctx.n - t_cnt'(1));

    // Stage ctx[0]: form avg*(n-1) + run; divider steps follow.
    assign w_sum = {r_prod_hi, r_prod_lo} + (2*CNT_W)'(r_run);

    always_comb begin
        w_step[0].rem = w_sum[2*CNT_W-1:CNT_W];
        w_step[0].lq  = w_sum[CNT_W-1:0];
        w_step[1]     = div_step(w_step[0].rem, w_step[0].lq, r_ctx[0].n);
        for (int k = 2; k <= CNT_W; k++) begin
            w_step[k] = div_step(r_rem[k-1], r_lq[k-1], r_ctx[k-1].n);
        end
    end

    // Final stage: merge the quotient and write back.
    assign w_last    = r_ctx[CNT_W];
    assign w_avg_new = w_last.drain ? '0 : (w_last.upd ? r_lq[CNT_W] : w_last.ent.avg);

    always_comb begin
        w_wd     = w_last.ent;
        w_wd.avg = w_avg_new;
        w_we     = 1'b0;
        w_wa     = w_last.addr;
        if (r_clr_busy) begin
            w_we = 1'b1;
            w_wa = r_clr_addr;
            w_wd = '0;
        end else if (w_adv && w_last.valid && !w_last.oor) begin
            w_we = 1'b1;
        end
    end

    // Memory ports
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_in_fire) begin
            r_rd <= r_mem[w_addr];
        end
    end

    // Pipeline: valid bits reset, payload advances with the valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            for (int k = 0; k <= CNT_W; k++) begin
                r_ctx[k].valid <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1.valid <= w_in_fire;
            r_ctx[0].valid <= r_s1.valid;
            for (int k = 1; k <= CNT_W; k++) begin
                r_ctx[k].valid <= r_ctx[k-1].valid;
            end
            r_out_valid <= w_last.valid;

            r_s1.oor    <= w_oor;
            r_s1.drain  <= (i_op == OP_DRAIN);
            r_s1.addr   <= w_addr;
            r_s1.gray   <= w_gray_sum[21:14];
            r_s1.area   <= i_in_area;
            r_s1.reload <= i_reload_background;

            r_ctx[0].oor     <= w_s1_ctx.oor;
            r_ctx[0].drain   <= w_s1_ctx.drain;
            r_ctx[0].addr    <= w_s1_ctx.addr;
            r_ctx[0].fg      <= w_s1_ctx.fg;
            r_ctx[0].ent     <= w_s1_ctx.ent;
            r_ctx[0].upd     <= w_s1_ctx.upd;
            r_ctx[0].n       <= w_s1_ctx.n;
            r_ctx[0].vis_out <= w_s1_ctx.vis_out;
            r_prod_hi <= w_prod[2*CNT_W-1:CNT_W];
            r_prod_lo <= w_prod[CNT_W-1:0];
            r_run     <= r_rd.run;

            for (int k = 1; k <= CNT_W; k++) begin
                r_ctx[k].oor     <= r_ctx[k-1].oor;
                r_ctx[k].drain   <= r_ctx[k-1].drain;
                r_ctx[k].addr    <= r_ctx[k-1].addr;
                r_ctx[k].fg      <= r_ctx[k-1].fg;
                r_ctx[k].ent     <= r_ctx[k-1].ent;
                r_ctx[k].upd     <= r_ctx[k-1].upd;
                r_ctx[k].n       <= r_ctx[k-1].n;
                r_ctx[k].vis_out <= r_ctx[k-1].vis_out;
                r_rem[k] <= w_step[k].rem;
                r_lq[k]  <= w_step[k].lq;
            end

            // Out-of-range requests report all zeros.
            if (w_last.oor) begin
                r_out_fg  <= 1'b0;
                r_out_avg <= '0;
                r_out_vis <= '0;
                r_out_has <= 1'b0;
            end else if (w_last.drain) begin
                r_out_fg  <= 1'b0;
                r_out_avg <= sat_out(w_last.ent.avg);
                r_out_vis <= sat_out(w_last.vis_out);
                r_out_has <= (w_last.ent.avg != '0);
            end else begin
                r_out_fg  <= w_last.fg;
                r_out_avg <= sat_out(w_avg_new);
                r_out_vis <= sat_out(w_last.vis_out);
                r_out_has <= (w_avg_new != '0);
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_foreground    = r_out_fg;
    assign o_dwell_average = r_out_avg;
    assign o_visit_count   = r_out_vis;
    assign o_has_data      = r_out_has;

    // No request may enter or leave while the clearing pass runs.
    a_clr_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> (!r_out_valid && !r_s1.valid))
        else $error("request in flight during clearing pass");

    // A request never reads the pixel that the write-back stage is about to update.
    a_no_raw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && !w_oor && w_last.valid && !w_last.oor) |-> (w_last.addr != w_addr))
        else $error("read of a pixel still being written back");

    // Drain results never flag foreground.
    a_drain_fg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_last.valid && w_last.drain) |=> !r_out_fg)
        else $error("drain result with foreground set");

endmodule
